// File: hw/rtl/id3tfx_pkg.sv
// ----------------------------------------------------------------------------
// id3tfx_pkg: shared types and constants of the ID3v2 text frame extractor
// Input and result words, parser phases, frame id table and text limits.
// ----------------------------------------------------------------------------
`default_nettype none

package id3tfx_pkg;

    // longest text run taken from one frame, in source bytes
    localparam int MAX_TEXT = 254;
    localparam int TEXT_W   = $clog2(MAX_TEXT + 1);
    // tag and frame byte counts are 28 bits (synchsafe tag size)
    localparam int SIZE_W   = 28;

    // field codes
    localparam logic [2:0] FIELD_TITLE  = 3'd0;
    localparam logic [2:0] FIELD_ALBUM  = 3'd1;
    localparam logic [2:0] FIELD_ARTIST = 3'd2;
    localparam logic [2:0] FIELD_YEAR   = 3'd3;
    localparam logic [2:0] FIELD_NONE   = 3'd4;

    // result kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // frame ids of interest
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;

    localparam logic [7:0] EXT_HDR_FLAG_BIT = 8'h40;

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_VERSION,
        PH_REVISION,
        PH_FLAGS,
        PH_TAGSIZE,
        PH_EXTSIZE,
        PH_EXTSKIP,
        PH_FRAMEID,
        PH_FRSIZE,
        PH_FRFLAGS,
        PH_ENCODING,
        PH_TEXT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_word_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] field_code;
        logic [7:0] out_byte;
        logic [7:0] text_encoding;
        logic       last;
    } out_word_t;

    // all result words caused by one input word
    typedef struct packed {
        logic [1:0]      n;
        out_word_t [2:0] w;
    } res_bundle_t;

    // expected header magic "ID3"
    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] m;
        unique case (pos)
            2'd0:    m = 8'h49;
            2'd1:    m = 8'h44;
            default: m = 8'h33;
        endcase
        return m;
    endfunction

    // frame id to field code
    function automatic logic [2:0] field_match(input logic [31:0] id);
        logic [2:0] f;
        unique case (id)
            ID_TIT2: f = FIELD_TITLE;
            ID_TALB: f = FIELD_ALBUM;
            ID_TPE1: f = FIELD_ARTIST;
            ID_TYER: f = FIELD_YEAR;
            default: f = FIELD_NONE;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/id3tfx_parse.sv
// ----------------------------------------------------------------------------
// id3tfx_parse: tag header and frame walker
// Holds the parser state and turns one accepted byte into up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tfx_parse (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_fire,
    input  wire id3tfx_pkg::in_word_t     in_word,
    output id3tfx_pkg::res_bundle_t       bundle
);
    import id3tfx_pkg::*;

    phase_t              phase_reg,     phase_next;
    logic [1:0]          pos_reg,       pos_next;
    logic [SIZE_W-1:0]   tag_left_reg,  tag_left_next;
    logic [31:0]         gather_reg,    gather_next;
    logic [15:0]         ext_left_reg,  ext_left_next;
    logic [31:0]         frame_id_reg,  frame_id_next;
    logic [SIZE_W-1:0]   frame_left_reg, frame_left_next;
    logic [2:0]          matched_reg,   matched_next;
    logic [TEXT_W-1:0]   text_cnt_reg,  text_cnt_next;
    logic [7:0]          enc_reg,       enc_next;
    logic [7:0]          flags_reg,     flags_next;
    logic                finished_reg,  finished_next;

    // state as seen by this word: start of file restarts everything
    phase_t              cur_phase;
    logic [1:0]          cur_pos;
    logic [SIZE_W-1:0]   cur_tag_left;
    logic [31:0]         cur_gather;
    logic [15:0]         cur_ext_left;
    logic [31:0]         cur_frame_id;
    logic [SIZE_W-1:0]   cur_frame_left;
    logic [2:0]          cur_matched;
    logic [TEXT_W-1:0]   cur_text_cnt;
    logic [7:0]          cur_enc;
    logic [7:0]          cur_flags;
    logic                cur_finished;
    logic                sof;
    logic [7:0]          b;

    assign sof            = in_word.start_of_file;
    assign b              = in_word.data_byte;
    assign cur_phase      = sof ? PH_MAGIC   : phase_reg;
    assign cur_pos        = sof ? 2'd0       : pos_reg;
    assign cur_tag_left   = sof ? '0         : tag_left_reg;
    assign cur_gather     = sof ? '0         : gather_reg;
    assign cur_ext_left   = sof ? '0         : ext_left_reg;
    assign cur_frame_id   = sof ? '0         : frame_id_reg;
    assign cur_frame_left = sof ? '0         : frame_left_reg;
    assign cur_matched    = sof ? FIELD_NONE : matched_reg;
    assign cur_text_cnt   = sof ? '0         : text_cnt_reg;
    assign cur_enc        = sof ? '0         : enc_reg;
    assign cur_flags      = sof ? '0         : flags_reg;
    assign cur_finished   = sof ? 1'b0       : finished_reg;

    // next state and result words
    always_comb
    begin
        logic [31:0]       gather_shift8;
        logic [31:0]       gather_shift7;
        logic [31:0]       id_shift;
        logic [SIZE_W-1:0] tl_dec;
        logic [SIZE_W-1:0] fl_dec;
        logic [TEXT_W-1:0] tc_dec;
        logic [32:0]       diff;
        logic [15:0]       ext_val;
        logic [2:0]        match;
        logic              go_next;
        logic [1:0]        n;
        out_word_t [2:0]   w;
        logic [1:0]        code;

        gather_shift8 = {cur_gather[23:0], b};
        gather_shift7 = {cur_gather[24:0], b[6:0]};
        id_shift      = {cur_frame_id[23:0], b};
        tl_dec        = cur_tag_left - SIZE_W'(1);
        fl_dec        = cur_frame_left - SIZE_W'(1);
        tc_dec        = cur_text_cnt - TEXT_W'(1);
        diff          = {5'b0, tl_dec} - {1'b0, cur_gather};
        ext_val       = gather_shift8[15:0];
        match         = field_match(cur_frame_id);
        go_next       = 1'b0;
        n             = 2'd0;
        w             = '0;
        code          = cur_matched[1:0];

        phase_next      = cur_phase;
        pos_next        = cur_pos;
        tag_left_next   = cur_tag_left;
        gather_next     = cur_gather;
        ext_left_next   = cur_ext_left;
        frame_id_next   = cur_frame_id;
        frame_left_next = cur_frame_left;
        matched_next    = cur_matched;
        text_cnt_next   = cur_text_cnt;
        enc_next        = cur_enc;
        flags_next      = cur_flags;
        finished_next   = cur_finished;

        unique case (cur_phase)
            PH_MAGIC:
            begin
                if (b != magic_byte(cur_pos))
                begin
                    phase_next = PH_DONE;
                end
                else if (cur_pos == 2'd2)
                begin
                    pos_next   = 2'd0;
                    phase_next = PH_VERSION;
                end
                else
                begin
                    pos_next = cur_pos + 2'd1;
                end
            end
            PH_VERSION:
            begin
                phase_next = (b == 8'd3 || b == 8'd4) ? PH_REVISION : PH_DONE;
            end
            PH_REVISION:
            begin
                phase_next = (b == 8'd0) ? PH_FLAGS : PH_DONE;
            end
            PH_FLAGS:
            begin
                flags_next  = b;
                gather_next = '0;
                pos_next    = 2'd0;
                phase_next  = PH_TAGSIZE;
            end
            PH_TAGSIZE:
            begin
                gather_next = gather_shift7;
                pos_next    = cur_pos + 2'd1;
                if (cur_pos == 2'd3)
                begin
                    tag_left_next = gather_shift7[SIZE_W-1:0];
                    gather_next   = '0;
                    if ((cur_flags & EXT_HDR_FLAG_BIT) != 8'd0)
                        phase_next = PH_EXTSIZE;
                    else
                        go_next = 1'b1;
                end
            end
            PH_EXTSIZE:
            begin
                gather_next = gather_shift8;
                pos_next    = cur_pos + 2'd1;
                if (cur_pos == 2'd3)
                begin
                    ext_left_next = ext_val;
                    tag_left_next = (cur_tag_left > {12'b0, ext_val})
                                  ? cur_tag_left - {12'b0, ext_val} : '0;
                    if (ext_val == 16'd0)
                        go_next = 1'b1;
                    else
                        phase_next = PH_EXTSKIP;
                end
            end
            PH_EXTSKIP:
            begin
                ext_left_next = cur_ext_left - 16'd1;
                if (ext_left_next == 16'd0)
                    go_next = 1'b1;
            end
            PH_FRAMEID:
            begin
                frame_id_next = id_shift;
                tag_left_next = tl_dec;
                pos_next      = cur_pos + 2'd1;
                if (cur_pos == 2'd3 || tl_dec == '0)
                begin
                    pos_next    = 2'd0;
                    gather_next = '0;
                    phase_next  = (id_shift != 32'd0 && tl_dec >= SIZE_W'(6))
                                ? PH_FRSIZE : PH_DONE;
                end
            end
            PH_FRSIZE:
            begin
                gather_next   = gather_shift8;
                tag_left_next = tl_dec;
                pos_next      = cur_pos + 2'd1;
                if (cur_pos == 2'd3)
                begin
                    pos_next   = 2'd0;
                    phase_next = PH_FRFLAGS;
                end
            end
            PH_FRFLAGS:
            begin
                tag_left_next = tl_dec;
                pos_next      = cur_pos + 2'd1;
                if (cur_pos == 2'd1)
                begin
                    pos_next = 2'd0;
                    // clamp frame size to the bytes left in the tag
                    if (diff[32])
                    begin
                        frame_left_next = tl_dec;
                        tag_left_next   = '0;
                    end
                    else
                    begin
                        frame_left_next = cur_gather[SIZE_W-1:0];
                        tag_left_next   = diff[SIZE_W-1:0];
                    end
                    matched_next = match;
                    code         = match[1:0];
                    if (frame_left_next == '0)
                    begin
                        // empty text frame closes the field at once
                        if (match != FIELD_NONE)
                        begin
                            w[0].kind = KIND_END;
                            n         = 2'd1;
                        end
                        go_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = (match != FIELD_NONE) ? PH_ENCODING : PH_SKIP;
                    end
                end
            end
            PH_ENCODING:
            begin
                enc_next        = b;
                frame_left_next = fl_dec;
                text_cnt_next   = (fl_dec < SIZE_W'(MAX_TEXT))
                                ? fl_dec[TEXT_W-1:0] : TEXT_W'(MAX_TEXT);
                finished_next   = 1'b0;
                if (text_cnt_next == '0)
                begin
                    w[0].kind          = KIND_END;
                    w[0].text_encoding = b;
                    n                  = 2'd1;
                    if (fl_dec == '0)
                        go_next = 1'b1;
                    else
                        phase_next = PH_SKIP;
                end
                else
                begin
                    phase_next = PH_TEXT;
                end
            end
            PH_TEXT:
            begin
                frame_left_next = fl_dec;
                text_cnt_next   = tc_dec;
                if (!cur_finished)
                begin
                    if (b == 8'd0)
                    begin
                        w[0].kind     = KIND_END;
                        n             = 2'd1;
                        finished_next = 1'b1;
                    end
                    else if (b[7])
                    begin
                        // two-byte utf-8 sequence
                        w[0].out_byte = {2'b11, 4'b0000, b[7:6]};
                        w[1].out_byte = {2'b10, b[5:0]};
                        w[2].kind     = KIND_END;
                        n             = (tc_dec == '0) ? 2'd3 : 2'd2;
                    end
                    else
                    begin
                        w[0].out_byte = b;
                        w[1].kind     = KIND_END;
                        n             = (tc_dec == '0) ? 2'd2 : 2'd1;
                    end
                    for (int i = 0; i < 3; i++)
                        w[i].text_encoding = cur_enc;
                end
                if (tc_dec == '0)
                begin
                    if (fl_dec == '0)
                        go_next = 1'b1;
                    else
                        phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                frame_left_next = fl_dec;
                if (fl_dec == '0)
                    go_next = 1'b1;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // move on to the next frame header
        if (go_next)
        begin
            pos_next      = 2'd0;
            frame_id_next = '0;
            matched_next  = FIELD_NONE;
            phase_next    = (tag_left_next == '0) ? PH_DONE : PH_FRAMEID;
        end

        // field code and last mark on the emitted words
        for (int i = 0; i < 3; i++)
        begin
            w[i].field_code = code;
            w[i].last       = (2'(i) == n - 2'd1);
        end

        bundle.n = n;
        bundle.w = w;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC;
            pos_reg        <= 2'd0;
            tag_left_reg   <= '0;
            gather_reg     <= '0;
            ext_left_reg   <= '0;
            frame_id_reg   <= '0;
            frame_left_reg <= '0;
            matched_reg    <= FIELD_NONE;
            text_cnt_reg   <= '0;
            enc_reg        <= '0;
            flags_reg      <= '0;
            finished_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            tag_left_reg   <= tag_left_next;
            gather_reg     <= gather_next;
            ext_left_reg   <= ext_left_next;
            frame_id_reg   <= frame_id_next;
            frame_left_reg <= frame_left_next;
            matched_reg    <= matched_next;
            text_cnt_reg   <= text_cnt_next;
            enc_reg        <= enc_next;
            flags_reg      <= flags_next;
            finished_reg   <= finished_next;
        end
    end

    // once the walk is over, only a new file wakes the parser
    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg == PH_DONE && !sof) |=> (phase_reg == PH_DONE))
        else $error("parser left done without start of file");

    // results come only from frame flags, encoding or text bytes
    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (bundle.n != 2'd0) |->
        (cur_phase == PH_FRFLAGS || cur_phase == PH_ENCODING || cur_phase == PH_TEXT))
        else $error("result emitted from a non-text phase");

endmodule

`default_nettype wire

// File: hw/rtl/id3tfx_obuf.sv
// ----------------------------------------------------------------------------
// id3tfx_obuf: result word buffer
// Holds the up to three words of one input and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tfx_obuf (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire id3tfx_pkg::res_bundle_t  bundle,
    output logic                          can_load,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output id3tfx_pkg::out_word_t         out_word
);
    import id3tfx_pkg::*;

    out_word_t [2:0] held_reg;
    logic [1:0]      idx_reg,  idx_next;
    logic [1:0]      left_reg, left_next;
    logic            out_fire;

    assign out_valid = (left_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;
    // room when empty or when the last word leaves this cycle
    assign can_load  = (left_reg == 2'd0) || (left_reg == 2'd1 && out_ready);

    // word select
    always_comb
    begin
        case (idx_reg)
            2'd0:    out_word = held_reg[0];
            2'd1:    out_word = held_reg[1];
            default: out_word = held_reg[2];
        endcase
    end

    // read pointer and fill count
    always_comb
    begin
        idx_next  = idx_reg;
        left_next = left_reg;
        if (load)
        begin
            idx_next  = 2'd0;
            left_next = bundle.n;
        end
        else if (out_fire)
        begin
            idx_next  = idx_reg + 2'd1;
            left_next = left_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            left_reg <= 2'd0;
        end
        else
        begin
            idx_reg  <= idx_next;
            left_reg <= left_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
            held_reg <= bundle.w;
    end

    // pointer never runs past the three held words
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, idx_reg} + {1'b0, left_reg}) <= 3'd3))
        else $error("result buffer pointer out of range");

    // last mark agrees with the fill count
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.last == (left_reg == 2'd1)))
        else $error("last mark does not match remaining words");

endmodule

`default_nettype wire

// File: hw/rtl/id3v2_text_frame_extractor.sv
// ----------------------------------------------------------------------------
// id3v2_text_frame_extractor: ID3v2 title, album, artist and year extractor
// Feed a file's bytes from its first byte; the block returns UTF-8 text words.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready / in_word carry one file byte per word;
// start_of_file marks byte zero of a file and restarts the parser.
// Output channel: out_valid / out_ready / out_word carry UTF-8 text bytes and
// end-of-field markers, tagged with field code and the frame's encoding byte;
// last marks the final result word caused by one input word.
// Latency: the first result of an input word is offered the cycle after the
// word is accepted.
// Throughput: one input word per cycle while each word gives at most one
// result and out_ready is high; a word that gives two or three results holds
// in_ready low while the three-word result buffer drains.
// Stall: when out_ready is low the held results stay put and in_ready stays
// low while the buffer holds any result word.
// Reset: rst_n clears the parser to wait for a header and empties the buffer;
// bytes after a bad header or the end of the tag are dropped until the next
// start_of_file.
// ----------------------------------------------------------------------------
`default_nettype none

module id3v2_text_frame_extractor (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire id3tfx_pkg::in_word_t   in_word,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output id3tfx_pkg::out_word_t       out_word
);
    import id3tfx_pkg::*;

    res_bundle_t bundle;
    logic        in_fire;

    assign in_fire = in_valid && in_ready;

    // header and frame walker
    id3tfx_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_word (in_word),
        .bundle  (bundle)
    );

    // result buffer
    id3tfx_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .bundle    (bundle),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire
